// ----- design/irt_pkg.sv -----
// Shared types, constants and helpers of the integer to radix text unit.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

  // Defaults of the top-level parameters.
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_WIDTH_DEF  = 60;

  // Fixed field widths of the ports.
  localparam int IN_VALUE_W = 32;
  localparam int FIELD_W    = 6;
  localparam int CHAR_W     = 8;

  // Digit store geometry.
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = 5;
  localparam int DIGIT_W     = 6;

  // Restoring division retires this many quotient bits per cycle.
  localparam int DIV_STEPS = 8;

  localparam logic [FIELD_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [FIELD_W-1:0] RADIX_MAX = 6'd36;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] ASC_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASC_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] ASC_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASC_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASC_X     = 8'h78;
  localparam logic [CHAR_W-1:0] ASC_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] ASC_LC_A  = 8'h61;

  // Padding modes.
  typedef enum logic [1:0] {
    MODE_RIGHT = 2'd0,
    MODE_ZERO  = 2'd1,
    MODE_LEFT  = 2'd2
  } mode_t;

  // Kind of character put out in one cycle.
  typedef enum logic [2:0] {
    CH_SPACE,
    CH_SIGN,
    CH_ZERO,
    CH_X,
    CH_DIGIT
  } char_kind_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_ROUTE,
    ST_PAD_PRE,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_ZPAD,
    ST_DIGITS,
    ST_PAD_POST
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       setup;
    logic       pad_dec;
    logic       digit_dec;
    logic       emit;
    char_kind_t kind;
    logic       last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  radix_ok;
    logic  div_done;
    mode_t mode;
    logic  sgn;
    logic  pfx;
    logic  pad_zero;
    logic  pad_one;
    logic  digit_zero;
  } status_t;

  // Mode three is treated as left-justified.
  function automatic mode_t norm_mode(input logic [1:0] m);
    mode_t r;
    unique case (m)
      2'd0:    r = MODE_RIGHT;
      2'd1:    r = MODE_ZERO;
      default: r = MODE_LEFT;
    endcase
    return r;
  endfunction

  // ASCII code of one digit value.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASC_UC_A : ASC_LC_A;
    if (d < 6'd10) begin
      return ASC_ZERO + {2'b00, d};
    end else begin
      return base + {2'b00, d} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/irt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module irt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/irt_ctrl.sv -----
// Controller of the integer to radix text unit: sequences division,
// field setup and the character phases. Depends on irt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irt_ctrl
  import irt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  state_t after_pre, after_sign, after_pfx, after_digits, first_out;

  // Phase order: pad before, sign, prefix, zero pad, digits, pad after.
  always_comb begin
    after_digits = (st.mode == MODE_LEFT && !st.pad_zero) ? ST_PAD_POST : ST_IDLE;
    after_pfx    = (st.mode == MODE_ZERO && !st.pad_zero) ? ST_ZPAD : ST_DIGITS;
    after_sign   = st.pfx ? ST_PFX0 : after_pfx;
    after_pre    = st.sgn ? ST_SIGN : after_sign;
    first_out    = (st.mode == MODE_RIGHT && !st.pad_zero) ? ST_PAD_PRE : after_pre;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (start && st.radix_ok) state_nxt = ST_DIV;
      ST_DIV:      if (st.div_done) state_nxt = ST_SETUP;
      ST_SETUP:    state_nxt = ST_ROUTE;
      ST_ROUTE:    state_nxt = first_out;
      ST_PAD_PRE:  if (st.pad_one) state_nxt = after_pre;
      ST_SIGN:     state_nxt = after_sign;
      ST_PFX0:     state_nxt = ST_PFXX;
      ST_PFXX:     state_nxt = after_pfx;
      ST_ZPAD:     if (st.pad_one) state_nxt = ST_DIGITS;
      ST_DIGITS:   if (st.digit_zero) state_nxt = after_digits;
      ST_PAD_POST: if (st.pad_one) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd      = '0;
    cmd.kind = CH_SPACE;
    busy     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:     cmd.load = start;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_SETUP:    cmd.setup = 1'b1;
      ST_ROUTE:    cmd.emit = 1'b0;
      ST_PAD_PRE: begin
        cmd.emit    = 1'b1;
        cmd.kind    = CH_SPACE;
        cmd.pad_dec = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit = 1'b1;
        cmd.kind = CH_SIGN;
      end
      ST_PFX0: begin
        cmd.emit = 1'b1;
        cmd.kind = CH_ZERO;
      end
      ST_PFXX: begin
        cmd.emit = 1'b1;
        cmd.kind = CH_X;
      end
      ST_ZPAD: begin
        cmd.emit    = 1'b1;
        cmd.kind    = CH_ZERO;
        cmd.pad_dec = 1'b1;
      end
      ST_DIGITS: begin
        cmd.emit      = 1'b1;
        cmd.kind      = CH_DIGIT;
        cmd.digit_dec = 1'b1;
      end
      ST_PAD_POST: begin
        cmd.emit    = 1'b1;
        cmd.kind    = CH_SPACE;
        cmd.pad_dec = 1'b1;
      end
      default:     cmd.emit = 1'b0;
    endcase
    cmd.last = cmd.emit && (state_nxt == ST_IDLE);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/irt_dp.sv -----
// Datapath of the integer to radix text unit: operand registers, the
// digit-by-digit divider, the digit store, field counters and the output
// register. Depends on irt_pkg and irt_ram.
`timescale 1ns / 1ps
`default_nettype none

module irt_dp
  import irt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_VALUE_W-1:0] in_value,
  input  wire logic [FIELD_W-1:0]    in_radix,
  input  wire logic [FIELD_W-1:0]    in_width,
  input  wire logic [FIELD_W-1:0]    in_precision,
  input  wire logic [1:0]            in_mode,
  input  wire logic                  in_signed_form,
  input  wire logic                  in_hex_prefix,
  input  wire logic                  in_upper_case,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  output logic                       out_valid,
  output logic [CHAR_W-1:0]          out_char,
  output logic                       out_last
);

  // Dividend is padded up to whole groups of division steps.
  localparam int DIV_W  = ((VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int CHUNKS = DIV_W / DIV_STEPS;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  // Operand registers.
  logic [DIV_W-1:0]   sh_r, sh_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]      chunk_r, chunk_nxt;
  logic [5:0]         ndig_r, ndig_nxt;
  logic [FIELD_W-1:0] radix_r, width_r, prec_r;
  mode_t              mode_r;
  logic               sgn_r, pfx_r, upper_r, neg_r, mag_zero_r;

  // Field counters.
  logic [5:0] pc_r, pc_nxt;
  logic [5:0] di_r, di_nxt;

  // Output register.
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r;

  logic [VALUE_BITS-1:0] val_in, mag_in;
  logic                  neg_in;
  logic [DIGIT_W:0]      div_rem;
  logic [DIV_W-1:0]      div_quo;
  logic                  chunk_last, we;
  logic [DIGIT_W-1:0]    rdata, digit;

  logic [5:0] w_sat, p_sat, p_sel;
  logic [6:0] w_eff, used, x_len;

  // Sign handling of the incoming value.
  always_comb begin
    val_in = in_value[VALUE_BITS-1:0];
    neg_in = in_signed_form && val_in[VALUE_BITS-1];
    mag_in = neg_in ? (~val_in + 1'b1) : val_in;
  end

  // One cycle of restoring division: DIV_STEPS quotient bits.
  always_comb begin
    div_rem = {1'b0, rem_r};
    div_quo = sh_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      div_rem = {div_rem[DIGIT_W-1:0], div_quo[DIV_W-1]};
      div_quo = {div_quo[DIV_W-2:0], 1'b0};
      if (div_rem >= {1'b0, radix_r}) begin
        div_rem    = div_rem - {1'b0, radix_r};
        div_quo[0] = 1'b1;
      end
    end
  end

  assign chunk_last = (chunk_r == CW'(CHUNKS - 1));
  assign we         = cmd.div_step && chunk_last;

  // Division control registers.
  always_comb begin
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    ndig_nxt  = ndig_r;
    if (cmd.load) begin
      sh_nxt    = DIV_W'(mag_in);
      rem_nxt   = '0;
      chunk_nxt = '0;
      ndig_nxt  = '0;
    end else if (cmd.div_step) begin
      sh_nxt = div_quo;
      if (chunk_last) begin
        rem_nxt   = '0;
        chunk_nxt = '0;
        ndig_nxt  = ndig_r + 6'd1;
      end else begin
        rem_nxt   = div_rem[DIGIT_W-1:0];
        chunk_nxt = chunk_r + 1'b1;
      end
    end
  end

  // Field geometry: digit count, effective width and padding.
  always_comb begin
    w_sat = ({1'b0, width_r} > 7'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width_r;
    p_sat = ({1'b0, prec_r} > 7'(MAX_WIDTH - 3)) ? 6'(MAX_WIDTH - 3) : prec_r;
    if (mag_zero_r) begin
      p_sel = 6'd1;
    end else if (p_sat == '0) begin
      p_sel = ndig_r;
    end else begin
      p_sel = p_sat;
    end
    x_len = pfx_r ? 7'd2 : 7'd0;
    if (w_sat == '0 || w_sat < p_sel) begin
      w_eff = {1'b0, p_sel} + x_len;
    end else begin
      w_eff = {1'b0, w_sat};
    end
    used = {1'b0, p_sel} + x_len + {6'd0, sgn_r};
  end

  // Pad and digit counters.
  always_comb begin
    pc_nxt = pc_r;
    di_nxt = di_r;
    if (cmd.setup) begin
      pc_nxt = (w_eff > used) ? 6'(w_eff - used) : 6'd0;
      di_nxt = p_sel - 6'd1;
    end else begin
      if (cmd.pad_dec) pc_nxt = pc_r - 6'd1;
      if (cmd.digit_dec) di_nxt = di_r - 6'd1;
    end
  end

  // Digit store, least significant digit at address zero.
  irt_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(ndig_r[STORE_AW-1:0]),
    .wdata(div_rem[DIGIT_W-1:0]),
    .raddr(di_nxt[STORE_AW-1:0]),
    .rdata(rdata)
  );

  // Digits above those computed are leading zeros.
  assign digit = (di_r < ndig_r) ? rdata : '0;

  // Character selection.
  always_comb begin
    unique case (cmd.kind)
      CH_SPACE: out_char_nxt = ASC_SPACE;
      CH_SIGN:  out_char_nxt = neg_r ? ASC_MINUS : ASC_PLUS;
      CH_ZERO:  out_char_nxt = ASC_ZERO;
      CH_X:     out_char_nxt = ASC_X;
      CH_DIGIT: out_char_nxt = digit_char(digit, upper_r);
      default:  out_char_nxt = ASC_SPACE;
    endcase
  end

  // Status for the controller.
  always_comb begin
    st.radix_ok   = (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX);
    st.div_done   = chunk_last && (div_quo == '0);
    st.mode       = mode_r;
    st.sgn        = sgn_r;
    st.pfx        = pfx_r;
    st.pad_zero   = (pc_r == 6'd0);
    st.pad_one    = (pc_r == 6'd1);
    st.digit_zero = (di_r == 6'd0);
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    ndig_r     <= ndig_nxt;
    pc_r       <= pc_nxt;
    di_r       <= di_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= cmd.last;
    if (cmd.load) begin
      radix_r    <= in_radix;
      width_r    <= in_width;
      prec_r     <= in_precision;
      mode_r     <= norm_mode(in_mode);
      sgn_r      <= in_signed_form;
      pfx_r      <= in_hex_prefix;
      upper_r    <= in_upper_case;
      neg_r      <= neg_in;
      mag_zero_r <= (mag_in == '0);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chunk_r     <= chunk_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ----- design/integer_to_radix_text_unit.sv -----
// Top level of the integer to radix text unit: controller plus datapath.
// Depends on irt_pkg, irt_ctrl and irt_dp.
//
// Usage: drive the in_ fields and raise start while busy is low; the item
// is taken at that clock edge and busy stays high until its text is out.
// The text leaves one ASCII character per cycle on out_char, marked by
// out_valid, most significant character first; out_last marks the final
// character. An item with a radix outside 2 to 36 is taken and gives no
// characters.
// Timing: after the start cycle the divider works one digit at a time,
// retiring eight quotient bits a cycle, and stops once the quotient is
// zero (at least one digit). The setup and route states follow, then
// one character per cycle.
// The next item can be started in the cycle in which the last character
// is on the outputs.
// Reset returns the controller to idle and drops out_valid; the digit
// store needs no clearing. The receiver cannot hold characters off.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_text_unit
  import irt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [IN_VALUE_W-1:0] in_value,
  input  wire logic [FIELD_W-1:0]    in_radix,
  input  wire logic [FIELD_W-1:0]    in_width,
  input  wire logic [FIELD_W-1:0]    in_precision,
  input  wire logic [1:0]            in_mode,
  input  wire logic                  in_signed_form,
  input  wire logic                  in_hex_prefix,
  input  wire logic                  in_upper_case,
  output logic                       out_valid,
  output logic [CHAR_W-1:0]          out_char,
  output logic                       out_last
);

  cmd_t    cmd;
  status_t st;

  // Sequencer.
  irt_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  // Divider, digit store and character output.
  irt_dp #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .in_width      (in_width),
    .in_precision  (in_precision),
    .in_mode       (in_mode),
    .in_signed_form(in_signed_form),
    .in_hex_prefix (in_hex_prefix),
    .in_upper_case (in_upper_case),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
